// ===== hw/rtl/thread_key_table_macros.svh =====
// Assertion macros used by the thread key table checker, tkt_checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef THREAD_KEY_TABLE_MACROS_SVH
`define THREAD_KEY_TABLE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define TKT_ASSERT_IMP(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("thread key table assertion failed");

// Antecedent implies consequent in the next cycle.
`define TKT_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("thread key table assertion failed");

`endif

// ===== hw/rtl/tkt_pkg.sv =====
// Shared types and constants for the thread key table.
// No dependencies; imported by every other file of the block but the macro header.
package tkt_pkg;

  // Fixed field widths of the request and response words
  localparam int CMD_W     = 2;
  localparam int THREAD_W  = 2;
  localparam int KEY_W     = 8;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int KEY_OUT_W = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_SET    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_NO_FREE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  // Field write enables of the per-thread slot store
  typedef struct packed {
    logic seq_we;
    logic val_we;
  } slot_we_t;

endpackage

// ===== hw/rtl/tkt_ifs.sv =====
// Valid/ready channel interfaces for the thread key table request and response words.
// Depends on tkt_pkg for the field widths.
interface tkt_req_if import tkt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [THREAD_W-1:0] thread;
  logic [KEY_W-1:0]    key;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, cmd, thread, key, value, input ready);
  modport sink (input valid, cmd, thread, key, value, output ready);
endinterface

interface tkt_rsp_if import tkt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [KEY_OUT_W-1:0] key_out;
  logic [VALUE_W-1:0]   value_out;

  modport source (output valid, status, key_out, value_out, input ready);
  modport sink (input valid, status, key_out, value_out, output ready);
endinterface

// ===== hw/rtl/tkt_key_store.sv =====
// Key sequence memory with in-use bits and a lowest-free-key encoder.
// Depends on tkt_pkg; instantiated by thread_key_table.
module tkt_key_store import tkt_pkg::*; #(
  parameter int KEYS     = 64,
  parameter int SEQ_BITS = 16,
  localparam int KW      = $clog2(KEYS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [KW-1:0]       rd_addr,
  output logic [SEQ_BITS-1:0] rd_data,
  input  logic                wr_en,
  input  logic [KW-1:0]       wr_addr,
  input  logic [SEQ_BITS-1:0] wr_data,
  output logic [KW-1:0]       free_idx,
  output logic                free_any
);

  logic [SEQ_BITS-1:0] mem [KEYS];
  logic [KEYS-1:0]     used;
  logic [KEYS-1:0]     avail;
  logic [KEYS-1:0]     lowest;

  // Write port and registered read; the controller never reads and writes in one cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Track the parity bit of each key: set while the key is in use
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (wr_en) begin
      used[wr_addr] <= wr_data[0];
    end
  end

  // Isolate the lowest free key and encode it
  assign avail    = ~used;
  assign lowest   = avail & (~avail + KEYS'(1));
  assign free_any = |avail;

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < KEYS; i++) begin
      if (lowest[i]) begin
        free_idx = free_idx | KW'(i);
      end
    end
  end

endmodule

// ===== hw/rtl/tkt_slot_store.sv =====
// Per-thread slot store: recorded sequence and value per (thread, key).
// Depends on tkt_pkg; instantiated by thread_key_table.
module tkt_slot_store import tkt_pkg::*; #(
  parameter int DEPTH      = 256,
  parameter int SEQ_BITS   = 16,
  parameter int VALUE_BITS = 32,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [SEQ_BITS-1:0]   rd_seq,
  output logic [VALUE_BITS-1:0] rd_val,
  input  slot_we_t              we,
  input  logic [AW-1:0]         wr_addr,
  input  logic [SEQ_BITS-1:0]   wr_seq,
  input  logic [VALUE_BITS-1:0] wr_val
);

  // One word per slot, written per field
  logic [SEQ_BITS-1:0]   seq_mem [DEPTH];
  logic [VALUE_BITS-1:0] val_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we.seq_we) begin
      seq_mem[wr_addr] <= wr_seq;
    end
    if (we.val_we) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (rd_en) begin
      rd_seq <= seq_mem[rd_addr];
      rd_val <= val_mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/thread_key_table.sv =====
// Thread key table: handle table with generation counters and per-thread values.
// Depends on tkt_pkg, tkt_ifs, tkt_key_store and tkt_slot_store.
//
// Usage:
//   req carries one command word (cmd, thread, key, value); rsp returns one
//   word (status, key_out, value_out) for every accepted command, in order.
//   Both are valid/ready channels; a word moves when valid and ready are high.
// Command flow:
//   The accept cycle reads the key sequence memory and the slot memory; the
//   execute state then checks, writes back and loads the response register.
//   A new command is taken only once the execute state ends, and that state
//   waits while the response register is full and rsp.ready is low.
// Reset:
//   rst clears the in-use bits at once, then a clearing pass writes zero to
//   every key sequence and every slot value, stepping through all THREADS*KEYS
//   slot addresses. req.ready stays low during the pass.
// Stall:
//   A response waits in its register while rsp.ready is low; a new command is
//   still taken, and its result holds in the execute cycle until the
//   register frees.
module thread_key_table import tkt_pkg::*; #(
  parameter int KEYS       = 64,
  parameter int THREADS    = 4,
  parameter int SEQ_BITS   = 16,
  parameter int VALUE_BITS = 32
) (
  input logic       clk,
  input logic       rst,
  tkt_req_if.sink   req,
  tkt_rsp_if.source rsp
);

  localparam int KW    = $clog2(KEYS);
  localparam int SLOTS = THREADS * KEYS;
  localparam int SW    = $clog2(SLOTS);
  localparam int TW    = (THREADS > 1) ? $clog2(THREADS) : 1;

  state_t state, state_next;
  logic [SW-1:0] clr_addr;

  // Command held for the execute cycle
  cmd_t                  op;
  logic [KW-1:0]         kidx;
  logic [SW-1:0]         saddr;
  logic [VALUE_BITS-1:0] val;
  logic                  key_bad;
  logic                  no_free;

  // Response register
  logic                 out_valid;
  status_t              out_status;
  logic [KEY_OUT_W-1:0] out_key;
  logic [VALUE_W-1:0]   out_value;

  // Memory ports
  logic                  key_rd_en;
  logic [KW-1:0]         key_rd_addr;
  logic [SEQ_BITS-1:0]   key_rd_data;
  logic                  key_wr_en;
  logic [KW-1:0]         key_wr_addr;
  logic [SEQ_BITS-1:0]   key_wr_data;
  logic [KW-1:0]         free_idx;
  logic                  free_any;
  logic                  slot_rd_en;
  logic [SEQ_BITS-1:0]   slot_rd_seq;
  logic [VALUE_BITS-1:0] slot_rd_val;
  slot_we_t              slot_we;
  logic [SW-1:0]         slot_wr_addr;
  logic [SEQ_BITS-1:0]   slot_wr_seq;
  logic [VALUE_BITS-1:0] slot_wr_val;

  // Request decode
  logic                  accept;
  logic [THREAD_W-1:0]   thr_fold;
  logic [TW-1:0]         thr_idx;
  logic [KW-1:0]         key_in;
  logic [SW-1:0]         saddr_in;
  logic                  key_bad_in;

  logic                 load_out;
  status_t              status_next;
  logic [KEY_OUT_W-1:0] key_out_next;
  logic [VALUE_W-1:0]   value_out_next;
  logic                 stale;

  tkt_key_store #(
    .KEYS     (KEYS),
    .SEQ_BITS (SEQ_BITS)
  ) u_key_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (key_rd_en),
    .rd_addr  (key_rd_addr),
    .rd_data  (key_rd_data),
    .wr_en    (key_wr_en),
    .wr_addr  (key_wr_addr),
    .wr_data  (key_wr_data),
    .free_idx (free_idx),
    .free_any (free_any)
  );

  tkt_slot_store #(
    .DEPTH      (SLOTS),
    .SEQ_BITS   (SEQ_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_slot_store (
    .clk     (clk),
    .rd_en   (slot_rd_en),
    .rd_addr (saddr_in),
    .rd_seq  (slot_rd_seq),
    .rd_val  (slot_rd_val),
    .we      (slot_we),
    .wr_addr (slot_wr_addr),
    .wr_seq  (slot_wr_seq),
    .wr_val  (slot_wr_val)
  );

  assign accept = req.valid && req.ready;

  // Fold the thread index into range by repeated subtraction
  always_comb begin
    thr_fold = req.thread;
    for (int i = 0; i < (1 << THREAD_W) - 1; i++) begin
      if (int'(thr_fold) >= THREADS) begin
        thr_fold = thr_fold - THREAD_W'(THREADS);
      end
    end
  end

  assign thr_idx    = TW'(thr_fold);
  assign key_in     = KW'(req.key);
  assign key_bad_in = int'(req.key) >= KEYS;
  assign saddr_in   = SW'(thr_idx) * SW'(KEYS) + SW'(key_in);

  assign stale = (slot_rd_val != '0) && (slot_rd_seq != key_rd_data);

  // Next state, memory controls and response word
  always_comb begin
    state_next     = state;
    req.ready      = 1'b0;
    key_rd_en      = 1'b0;
    key_rd_addr    = (cmd_t'(req.cmd) == CMD_CREATE) ? free_idx : key_in;
    key_wr_en      = 1'b0;
    key_wr_addr    = kidx;
    key_wr_data    = key_rd_data + SEQ_BITS'(1);
    slot_rd_en     = 1'b0;
    slot_we        = '0;
    slot_wr_addr   = saddr;
    slot_wr_seq    = key_rd_data;
    slot_wr_val    = val;
    load_out       = 1'b0;
    status_next    = STAT_OK;
    key_out_next   = '0;
    value_out_next = '0;
    unique case (state)
      S_CLEAR: begin
        slot_we.val_we = 1'b1;
        slot_wr_addr   = clr_addr;
        slot_wr_val    = '0;
        key_wr_en      = int'(clr_addr) < KEYS;
        key_wr_addr    = KW'(clr_addr);
        key_wr_data    = '0;
        if (clr_addr == SW'(SLOTS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          key_rd_en  = 1'b1;
          slot_rd_en = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
          unique case (op)
            CMD_CREATE: begin
              if (no_free) begin
                status_next = STAT_NO_FREE;
              end else begin
                key_wr_en    = 1'b1;
                key_out_next = KEY_OUT_W'(kidx);
              end
            end
            CMD_DELETE: begin
              if (key_bad || !key_rd_data[0]) begin
                status_next = STAT_INVALID;
              end else begin
                key_wr_en = 1'b1;
              end
            end
            CMD_GET: begin
              if (key_bad) begin
                status_next = STAT_INVALID;
              end else if (stale) begin
                // Drop a value recorded under an older generation
                slot_we.val_we = 1'b1;
                slot_wr_val    = '0;
              end else begin
                value_out_next = VALUE_W'(slot_rd_val);
              end
            end
            CMD_SET: begin
              if (key_bad || !key_rd_data[0]) begin
                status_next = STAT_INVALID;
              end else begin
                slot_we.seq_we = 1'b1;
                slot_we.val_we = 1'b1;
              end
            end
            default: begin
              status_next = STAT_INVALID;
            end
          endcase
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // State and clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + SW'(1);
      end
    end
  end

  // Hold the accepted command for the execute cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= cmd_t'(req.cmd);
      kidx    <= key_rd_addr;
      saddr   <= saddr_in;
      val     <= VALUE_BITS'(req.value);
      key_bad <= key_bad_in;
      no_free <= !free_any;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= status_next;
      out_key    <= key_out_next;
      out_value  <= value_out_next;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.key_out   = out_key;
  assign rsp.value_out = out_value;

endmodule

// ===== hw/rtl/tkt_checker.sv =====
// Port-level assertions for the thread key table, bound to the top level.
// Depends on tkt_pkg and thread_key_table_macros.svh.
`include "thread_key_table_macros.svh"

module tkt_checker import tkt_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input logic [STATUS_W-1:0]  rsp_status,
  input logic [KEY_OUT_W-1:0] rsp_key_out,
  input logic [VALUE_W-1:0]   rsp_value_out
);

  // A stalled response word holds
  `TKT_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_key_out) && $stable(rsp_value_out))

  // One command in flight: no accept right after an accept
  `TKT_ASSERT_NEXT(a_single_cmd, clk, rst, req_valid && req_ready, !req_ready)

  // Only a successful create hands out a nonzero key
  `TKT_ASSERT_IMP(a_key_from_create, clk, rst, rsp_valid && rsp_key_out != '0, rsp_status == STAT_OK && rsp_value_out == '0)

  // Only a successful get returns a nonzero value
  `TKT_ASSERT_IMP(a_value_from_get, clk, rst, rsp_valid && rsp_value_out != '0, rsp_status == STAT_OK && rsp_key_out == '0)

endmodule

bind thread_key_table tkt_checker u_tkt_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_key_out   (rsp.key_out),
  .rsp_value_out (rsp.value_out)
);
